// ----- rtl/core/mbf_pkg.sv -----
package mbf_pkg;

    localparam int SET_W      = 32;
    localparam int SLOT_COUNT = 64;
    localparam int IDX_W      = $clog2(SLOT_COUNT);
    localparam int SCAN_W     = IDX_W + 1;
    localparam int CNT_W      = 7;

    // stream payload widths, rounded up to whole bytes
    localparam int S_DATA_W = ((SET_W + IDX_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((2 * CNT_W + SET_W + 7) / 8) * 8;

    typedef enum logic {
        KIND_INSERT = 1'b0,
        KIND_READ   = 1'b1
    } t_kind;

    typedef enum logic [1:0] {
        STAT_ADDED  = 2'd0,
        STAT_SUBSET = 2'd1,
        STAT_FULL   = 2'd2,
        STAT_READ   = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SCAN,
        ST_COMMIT
    } t_state;

    typedef struct packed {
        logic covered;  // candidate is a subset of, or equal to, the entry
        logic below;    // entry is a subset of the candidate
    } t_cmp;

endpackage

// ----- rtl/core/mbf_subset_cmp.sv -----
module mbf_subset_cmp (
    input  logic [mbf_pkg::SET_W-1:0] i_cand,
    input  logic [mbf_pkg::SET_W-1:0] i_entry,
    input  logic                      i_entry_valid,
    output mbf_pkg::t_cmp             o_cmp
);
    import mbf_pkg::*;

    always_comb begin
        o_cmp.covered = i_entry_valid && ((i_cand & ~i_entry) == '0);
        o_cmp.below   = i_entry_valid && ((i_entry & ~i_cand) == '0);
    end

endmodule

// ----- rtl/core/maximal_bitset_filter_core.sv -----
// Maximal-set filter over a table of SLOT_COUNT bitsets kept as an antichain.
// An insert walks every slot once through the table's single read port and
// one shared subset comparator, one slot per cycle, then commits. An insert
// is accepted in ST_IDLE, scans in ST_SCAN while the registered read fills
// and drains, and registers its result in ST_COMMIT. A read registers its
// result in ST_READ, and a zero candidate straight from ST_IDLE.
// One request is in work at a time, and a new request is taken only while the
// result register is empty or is being drained in that same cycle, so a
// stalled result holds off the input.
// Slot occupancy lives in per-slot valid flops cleared at reset, so the
// table needs no clearing pass and a free slot reads as zero.
module maximal_bitset_filter_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [mbf_pkg::S_DATA_W-1:0]  i_s_tdata,   // candidate, slot_index, zero pad
    input  logic                          i_s_tuser,   // kind
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [mbf_pkg::M_DATA_W-1:0]  o_m_tdata,   // removed_count, entry_count,
                                                       // read_value, zero pad
    output logic [1:0]                    o_m_tuser    // status
);
    import mbf_pkg::*;

    t_state                  r_state, n_state;
    logic [SCAN_W-1:0]       r_cnt, n_cnt;
    logic                    r_chk, n_chk;
    logic [IDX_W-1:0]        r_chk_idx, n_chk_idx;
    logic [SET_W-1:0]        r_cand, n_cand;
    logic [SLOT_COUNT-1:0]   r_valid, n_valid;
    logic [SLOT_COUNT-1:0]   r_rm, n_rm;
    logic                    r_covered, n_covered;
    logic [CNT_W-1:0]        r_rm_cnt, n_rm_cnt;
    logic                    r_free_found, n_free_found;
    logic [IDX_W-1:0]        r_free_idx, n_free_idx;
    logic [CNT_W-1:0]        r_occ, n_occ;

    logic                    r_mv, n_mv;
    t_status                 r_status, n_status;
    logic [CNT_W-1:0]        r_out_rm, n_out_rm;
    logic [CNT_W-1:0]        r_out_occ, n_out_occ;
    logic [SET_W-1:0]        r_out_val, n_out_val;

    logic [SET_W-1:0]        mem [SLOT_COUNT];
    logic [SET_W-1:0]        r_rd_data;
    logic                    rd_en;
    logic [IDX_W-1:0]        rd_addr;
    logic                    wr_en;

    logic                    accept;
    logic                    out_free;
    logic                    ent_valid;
    t_cmp                    cmp;
    logic [SET_W-1:0]        in_cand;
    logic [IDX_W-1:0]        in_idx;

    assign in_cand   = i_s_tdata[SET_W-1:0];
    assign in_idx    = i_s_tdata[SET_W+IDX_W-1:SET_W];
    assign out_free  = !r_mv || i_m_tready;
    assign o_s_tready = (r_state == ST_IDLE) && out_free;
    assign accept    = i_s_tvalid && o_s_tready;
    assign ent_valid = r_valid[r_chk_idx];

    assign o_m_tvalid = r_mv;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = {{(M_DATA_W - 2 * CNT_W - SET_W){1'b0}}, r_out_val, r_out_occ, r_out_rm};

    mbf_subset_cmp u_cmp (
        .i_cand        (r_cand),
        .i_entry       (r_rd_data),
        .i_entry_valid (ent_valid),
        .o_cmp         (cmp)
    );

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[r_free_idx] <= r_cand;
        end
    end

    always_comb begin
        n_state      = r_state;
        n_cnt        = r_cnt;
        n_chk        = 1'b0;
        n_chk_idx    = r_chk_idx;
        n_cand       = r_cand;
        n_valid      = r_valid;
        n_rm         = r_rm;
        n_covered    = r_covered;
        n_rm_cnt     = r_rm_cnt;
        n_free_found = r_free_found;
        n_free_idx   = r_free_idx;
        n_occ        = r_occ;
        n_mv         = r_mv && !i_m_tready;
        n_status     = r_status;
        n_out_rm     = r_out_rm;
        n_out_occ    = r_out_occ;
        n_out_val    = r_out_val;
        rd_en        = 1'b0;
        rd_addr      = r_cnt[IDX_W-1:0];
        wr_en        = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                rd_addr = in_idx;
                if (accept) begin
                    n_cand = in_cand;
                    if (t_kind'(i_s_tuser) == KIND_READ) begin
                        rd_en     = 1'b1;
                        n_chk_idx = in_idx;
                        n_state   = ST_READ;
                    end else if (in_cand == '0) begin
                        // empty set is covered by anything: discard at once
                        n_mv      = 1'b1;
                        n_status  = STAT_SUBSET;
                        n_out_rm  = '0;
                        n_out_occ = r_occ;
                        n_out_val = '0;
                    end else begin
                        n_cnt        = '0;
                        n_rm         = '0;
                        n_covered    = 1'b0;
                        n_rm_cnt     = '0;
                        n_free_found = 1'b0;
                        n_state      = ST_SCAN;
                    end
                end
            end
            ST_READ: begin
                n_mv      = 1'b1;
                n_status  = STAT_READ;
                n_out_rm  = '0;
                n_out_occ = r_occ;
                n_out_val = ent_valid ? r_rd_data : '0;
                n_state   = ST_IDLE;
            end
            ST_SCAN: begin
                // issue one slot read per cycle, check the slot read last cycle
                if (r_cnt < SCAN_W'(SLOT_COUNT)) begin
                    rd_en     = 1'b1;
                    n_chk     = 1'b1;
                    n_chk_idx = r_cnt[IDX_W-1:0];
                    n_cnt     = r_cnt + 1'b1;
                end
                if (r_chk) begin
                    if (cmp.covered) begin
                        n_covered = 1'b1;
                    end
                    if (cmp.below) begin
                        n_rm[r_chk_idx] = 1'b1;
                        n_rm_cnt        = r_rm_cnt + 1'b1;
                    end
                    if (!r_free_found && (!ent_valid || cmp.below)) begin
                        n_free_found = 1'b1;
                        n_free_idx   = r_chk_idx;
                    end
                end
                if ((r_cnt == SCAN_W'(SLOT_COUNT)) && !r_chk) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                n_mv      = 1'b1;
                n_out_val = '0;
                n_state   = ST_IDLE;
                if (r_covered) begin
                    n_status  = STAT_SUBSET;
                    n_out_rm  = '0;
                    n_out_occ = r_occ;
                end else if (r_free_found) begin
                    wr_en               = 1'b1;
                    n_valid             = r_valid & ~r_rm;
                    n_valid[r_free_idx] = 1'b1;
                    n_occ               = r_occ - r_rm_cnt + 1'b1;
                    n_status            = STAT_ADDED;
                    n_out_rm            = r_rm_cnt;
                    n_out_occ           = r_occ - r_rm_cnt + 1'b1;
                end else begin
                    // no free slot implies nothing was removed
                    n_status  = STAT_FULL;
                    n_out_rm  = '0;
                    n_out_occ = r_occ;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_chk   <= 1'b0;
            r_valid <= '0;
            r_occ   <= '0;
            r_mv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_chk   <= n_chk;
            r_valid <= n_valid;
            r_occ   <= n_occ;
            r_mv    <= n_mv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_chk_idx    <= n_chk_idx;
        r_cand       <= n_cand;
        r_rm         <= n_rm;
        r_covered    <= n_covered;
        r_rm_cnt     <= n_rm_cnt;
        r_free_found <= n_free_found;
        r_free_idx   <= n_free_idx;
        r_status     <= n_status;
        r_out_rm     <= n_out_rm;
        r_out_occ    <= n_out_occ;
        r_out_val    <= n_out_val;
    end

endmodule

// ----- sim/maximal_bitset_filter_checker.sv -----
module maximal_bitset_filter_checker
    import mbf_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_s_tvalid,
    input  logic                i_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,    // candidate, slot_index, zero pad
    input  logic                i_s_tuser,    // kind
    input  logic                i_m_tvalid,
    input  logic                i_m_tready,
    input  logic [M_DATA_W-1:0] i_m_tdata,    // removed_count, entry_count, read_value, zero pad
    input  logic [1:0]          i_m_tuser,    // status
    output int                  o_pending,
    output int                  o_mismatches
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_status          status;
        logic [CNT_W-1:0] removed;
        logic [CNT_W-1:0] entries;
        logic [SET_W-1:0] value;
    } t_reply;

    logic [SET_W-1:0] model_sets [SLOT_COUNT];
    int               model_count;
    t_reply           replies_due [$];
    int               mismatches = 0;

    function automatic logic [CNT_W-1:0] clip_count(int n);
        return (n > (1 << CNT_W) - 1) ? {CNT_W{1'b1}} : n[CNT_W-1:0];
    endfunction

    // Update the table for one request and return the reply it must produce.
    function automatic t_reply apply_request(t_kind kind, logic [SET_W-1:0] cand,
                                             logic [IDX_W-1:0] idx);
        t_reply r;
        logic   covered;
        int     removed;
        int     slot;
        r.status  = STAT_SUBSET;
        r.value   = '0;
        covered   = 1'b0;
        removed   = 0;
        slot      = -1;
        if (kind == KIND_READ) begin
            r.status = STAT_READ;
            if (int'(idx) < SLOT_COUNT)
                r.value = model_sets[idx];
        end else if (cand != '0) begin
            for (int i = 0; i < SLOT_COUNT; i++)
                if (model_sets[i] != '0 && (cand & ~model_sets[i]) == '0)
                    covered = 1'b1;
            if (!covered) begin
                // drop every stored subset, then fill the lowest free slot
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (model_sets[i] != '0 && (model_sets[i] & ~cand) == '0) begin
                        model_sets[i] = '0;
                        removed++;
                        if (model_count > 0)
                            model_count--;
                    end
                end
                for (int i = 0; i < SLOT_COUNT; i++)
                    if (slot < 0 && model_sets[i] == '0)
                        slot = i;
                if (slot >= 0) begin
                    model_sets[slot] = cand;
                    model_count++;
                    r.status = STAT_ADDED;
                end else begin
                    r.status = STAT_FULL;
                end
            end
        end
        r.removed = clip_count(removed);
        r.entries = clip_count(model_count);
        return r;
    endfunction

    function automatic void match_field(string field, logic [SET_W-1:0] want,
                                        logic [SET_W-1:0] seen);
        if (want !== seen) begin
            $error("%s mismatch: expected %0h, actual %0h", field, want, seen);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        t_reply seen;
        if (!i_rst_n) begin
            for (int i = 0; i < SLOT_COUNT; i++)
                model_sets[i] = '0;
            model_count = 0;
            replies_due.delete();
        end else begin
            // retire the result before queueing a request taken at the same edge
            if (i_m_tvalid && i_m_tready) begin
                seen.status  = t_status'(i_m_tuser);
                seen.removed = i_m_tdata[CNT_W-1:0];
                seen.entries = i_m_tdata[CNT_W +: CNT_W];
                seen.value   = i_m_tdata[2*CNT_W +: SET_W];
                if (replies_due.size() == 0) begin
                    $error("result with no request outstanding: status %0d", seen.status);
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    match_field("status", SET_W'(want.status), SET_W'(seen.status));
                    match_field("removed_count", SET_W'(want.removed),
                                SET_W'(seen.removed));
                    match_field("entry_count", SET_W'(want.entries),
                                SET_W'(seen.entries));
                    match_field("read_value", want.value, seen.value);
                end
            end
            if (i_s_tvalid && i_s_tready)
                replies_due.push_back(apply_request(t_kind'(i_s_tuser),
                                                    i_s_tdata[SET_W-1:0],
                                                    i_s_tdata[SET_W +: IDX_W]));
        end
        o_pending    <= replies_due.size();
        o_mismatches <= mismatches;
    end

endmodule

// ----- sim/maximal_bitset_filter_core_tb.sv -----
module maximal_bitset_filter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import mbf_pkg::*;

    localparam int               RAND_ITEMS  = 2000;
    localparam int               EPISODES    = 7;
    localparam int               LOW_W       = 24;
    localparam int               HOLD_CYCLES = 600;
    localparam int               DRAIN       = SLOT_COUNT + 10;
    localparam int               LIMIT       = 1000000;
    localparam logic [SET_W-1:0] UNIT        = 1;
    localparam logic [SET_W-1:0] LOW_MASK    = (UNIT << LOW_W) - UNIT;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_s_tvalid;
    logic                o_s_tready;
    logic [S_DATA_W-1:0] i_s_tdata;     // candidate, slot_index, zero pad
    logic                i_s_tuser;     // kind
    logic                o_m_tvalid;
    logic                i_m_tready;
    logic [M_DATA_W-1:0] o_m_tdata;     // removed_count, entry_count, read_value, zero pad
    logic [1:0]          o_m_tuser;     // status

    int   pending_count;
    int   mismatch_count;
    int   idle_pct;
    int   stall_pct;
    logic hold_req;
    int   cycle_count = 0;

    maximal_bitset_filter_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    maximal_bitset_filter_checker u_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (i_s_tvalid),
        .i_s_tready   (o_s_tready),
        .i_s_tdata    (i_s_tdata),
        .i_s_tuser    (i_s_tuser),
        .i_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .i_m_tdata    (o_m_tdata),
        .i_m_tuser    (o_m_tuser),
        .o_pending    (pending_count),
        .o_mismatches (mismatch_count)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Receiver: random stalls per phase, plus one long hold-off to back up the block.
    initial begin
        logic held;
        held = 1'b0;
        i_m_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !held) begin
                held = 1'b1;
                i_m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else begin
                i_m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    // Set n distinct bits among the low LOW_W positions.
    function automatic logic [SET_W-1:0] scatter_bits(int n);
        logic [SET_W-1:0] v;
        int               b;
        int               got;
        v   = '0;
        got = 0;
        while (got < n) begin
            b = $urandom_range(LOW_W - 1);
            if (!v[b]) begin
                v[b] = 1'b1;
                got++;
            end
        end
        return v;
    endfunction

    task automatic offer(input t_kind kind, input logic [SET_W-1:0] cand,
                         input logic [IDX_W-1:0] idx);
        logic [S_DATA_W-1:0] word;
        word                   = '0;
        word[SET_W-1:0]        = cand;
        word[SET_W +: IDX_W]   = idx;
        while ($urandom_range(99) < idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= word;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    initial begin
        logic [SET_W-1:0] recent [$];
        logic [SET_W-1:0] hi;
        logic [SET_W-1:0] cand;
        int               k;
        int               r;
        int               ep;
        int               ph;
        int               ep_len;
        i_rst_n    <= 1'b0;
        i_s_tvalid <= 1'b0;
        i_s_tdata  <= '0;
        i_s_tuser  <= KIND_INSERT;
        stall_pct  <= 0;
        hold_req   <= 1'b0;
        idle_pct   = 0;
        hi         = UNIT << LOW_W;
        k          = 4;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, zero candidate, cover / equal / disjoint, then a superset and two sets that overlap it
        offer(KIND_READ, $urandom(), '0);
        offer(KIND_READ, $urandom(), IDX_W'(SLOT_COUNT - 1));
        offer(KIND_INSERT, '0, '1);
        offer(KIND_INSERT, 32'h0000_000F, '0);
        offer(KIND_INSERT, 32'h0000_0003, 6'h2A);
        offer(KIND_INSERT, 32'h0000_000F, 6'h15);
        offer(KIND_INSERT, 32'h0000_00F0, '0);
        offer(KIND_INSERT, 32'h0000_0F00, '0);
        offer(KIND_READ, $urandom(), 6'd1);
        offer(KIND_INSERT, 32'h0000_0FFF, '0);
        offer(KIND_READ, $urandom(), 6'd0);
        offer(KIND_READ, $urandom(), 6'd2);
        offer(KIND_INSERT, 32'h00AA_AAAA, '0);
        offer(KIND_INSERT, 32'h0055_5555, '0);
        offer(KIND_READ, $urandom(), 6'd1);

        // Each episode opens with a sweep that clears the table; its candidates carry
        // one more tag bit above LOW_W so the next sweep clears them in turn.
        ep_len = RAND_ITEMS / EPISODES;
        for (int i = 0; i < RAND_ITEMS; i++) begin
            ph        = i * 4 / RAND_ITEMS;
            idle_pct  = (ph == 1) ? 70 : (ph == 3) ? 34 : 0;
            stall_pct <= (ph == 2) ? 70 : (ph == 3) ? 34 : 0;
            if (i == RAND_ITEMS / 2)
                hold_req <= 1'b1;
            if (i % ep_len == 0 && i / ep_len < EPISODES) begin
                ep = i / ep_len;
                k  = $urandom_range(3, 16);
                hi = (UNIT << (LOW_W + ep + 1)) - (UNIT << LOW_W);
                recent.delete();
                offer(KIND_INSERT, (UNIT << (LOW_W + ep)) - UNIT,
                      IDX_W'($urandom_range(SLOT_COUNT - 1)));
            end else begin
                r = $urandom_range(99);
                if (r < 15) begin
                    offer(KIND_READ, $urandom(), IDX_W'($urandom_range(SLOT_COUNT - 1)));
                end else begin
                    if (r < 17)
                        cand = '0;
                    else if (r < 20)
                        cand = $urandom() & (hi | LOW_MASK);
                    else if (r < 28 && recent.size() > 0)
                        cand = recent[$urandom_range(recent.size() - 1)]
                               & ~(UNIT << $urandom_range(LOW_W - 1));
                    else if (r < 36 && recent.size() > 0)
                        cand = recent[$urandom_range(recent.size() - 1)] | scatter_bits(2);
                    else if (r < 46)
                        cand = hi | scatter_bits(k + $urandom_range(1, 3));
                    else
                        cand = hi | scatter_bits(k);
                    offer(KIND_INSERT, cand, IDX_W'($urandom_range(SLOT_COUNT - 1)));
                    if (cand != '0) begin
                        recent.push_back(cand);
                        if (recent.size() > 8)
                            void'(recent.pop_front());
                    end
                end
            end
        end

        // full-width set clears everything and covers all that follows
        idle_pct  = 0;
        stall_pct <= 0;
        offer(KIND_INSERT, '1, '0);
        offer(KIND_INSERT, 32'h8000_0000, '0);
        offer(KIND_INSERT, '1, '1);
        offer(KIND_READ, $urandom(), 6'd0);
        offer(KIND_READ, $urandom(), 6'd1);
        i_s_tvalid <= 1'b0;

        do @(posedge i_clk); while (pending_count != 0);
        repeat (DRAIN) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
